@@ rtl/core/mcba_pkg.sv @@
// ----------------------------------------------------------------------------
// mcba_pkg
// Types and constants shared by the chain allocator controller and datapath.
// ----------------------------------------------------------------------------
package mcba_pkg;

    localparam int WA = 17;
    localparam logic [15:0] SIZE_DEAD = 16'hffff;

    localparam logic [1:0] HT_NORMAL  = 2'd0;
    localparam logic [1:0] HT_LAST    = 2'd1;
    localparam logic [1:0] HT_INVALID = 2'd2;

    localparam logic [1:0] FIT_FIRST   = 2'd0;
    localparam logic [1:0] FIT_BEST    = 2'd1;
    localparam logic [1:0] FIT_LAST    = 2'd2;
    localparam logic [1:0] FIT_LARGEST = 2'd3;

    typedef enum logic [2:0] {
        ACT_ALLOC     = 3'd0,
        ACT_FREE      = 3'd1,
        ACT_RESIZE    = 3'd2,
        ACT_QUERY     = 3'd3,
        ACT_CHECK     = 3'd4,
        ACT_FREE_OWN  = 3'd5,
        ACT_WRITE_HDR = 3'd6,
        ACT_NOP       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOMEM     = 2'd1,
        ST_DESTROYED = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  htype;
        logic [15:0] owner;
        logic [15:0] size;
    } t_hdr;

    localparam t_hdr HDR_DEAD = '{htype: HT_INVALID, owner: 16'd0, size: SIZE_DEAD};

    typedef struct packed {
        t_action     action;
        logic [15:0] req_size;
        logic [1:0]  fit_mode;
        logic [11:0] block;
        logic [15:0] owner;
        logic [1:0]  hdr_type;
        logic [15:0] hdr_size;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [11:0] block_out;
        logic [15:0] size_out;
    } t_result;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_A,
        OP_RD_Q,
        OP_LD_P,
        OP_LD_Q,
        OP_CALC_QA,
        OP_J_WQ,
        OP_J_WP,
        OP_AL_EVAL,
        OP_ADV,
        OP_PICK_BIG,
        OP_NOMEM_AL,
        OP_SET_FA,
        OP_AL_W_LO,
        OP_AL_W_HI,
        OP_AL_W_ALL,
        OP_RS_NOMEM,
        OP_RS_SPLIT1,
        OP_RS_SPLIT2,
        OP_RS_MOVE,
        OP_RS_OWN_EQ,
        OP_RS_OWN_SH,
        OP_FREE_W,
        OP_QUERY,
        OP_WALK_W,
        OP_HDR_W,
        OP_SET_ST,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        t_action    act;
        logic [1:0] mode;
        logic       p_valid;
        logic       p_free;
        logic [1:0] p_type;
        logic       q_free;
        logic       q_valid;
        logic       join_ovf;
        logic       next_oob;
        logic       req_gt;
        logic       req_lt;
        logic       split_need;
        logic       stop;
        logic       found;
        logic       fs_zero;
        logic       blk_zero;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_RD,
        S_LD,
        S_CHK,
        S_NEXT,
        S_J_TOP,
        S_J_RDQ,
        S_J_LDQ,
        S_J_CHK,
        S_J_WQ,
        S_J_WP,
        S_AL_EVAL,
        S_AL_END,
        S_AL_END2,
        S_AL_FA,
        S_AL_RD,
        S_AL_LD,
        S_AL_SPLIT,
        S_AL_WHI,
        S_RS_GROW,
        S_RS_SHR,
        S_RS_SP2,
        S_RS_MOVE,
        S_RS_FIN,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/mcba_datapath.sv @@
// ----------------------------------------------------------------------------
// mcba_datapath
// Header store, walk registers and result registers of the chain allocator.
// ----------------------------------------------------------------------------
module mcba_datapath #(
    parameter int ARENA_PARAS = 4096
) (
    input  logic              i_clk,
    input  mcba_pkg::t_req    i_req,
    input  logic [11:0]       i_arena_start,
    input  mcba_pkg::t_dp_cmd i_cmd,
    output mcba_pkg::t_dp_stat o_stat,
    output mcba_pkg::t_result o_result
);
    import mcba_pkg::*;

    localparam int AW = $clog2(ARENA_PARAS);
    localparam logic [WA-1:0] LIMIT = WA'(ARENA_PARAS);

    t_hdr r_mem [ARENA_PARAS];

    t_req          r_req;
    logic [WA-1:0] r_a;
    logic [WA-1:0] r_qa;
    logic [WA-1:0] r_fa;
    logic [WA-1:0] r_ba;
    t_hdr          r_p;
    t_hdr          r_q;
    t_hdr          r_rdata;
    logic          r_rd_oob;
    logic [15:0]   r_fs;
    logic [15:0]   r_bs;
    logic          r_found;
    logic          r_big;
    t_status       r_st;
    logic [11:0]   r_blk;
    logic [15:0]   r_sz;
    t_result       r_out;

    t_hdr          rd_hdr;
    logic [WA-1:0] next_a;
    logic [WA-1:0] split_a;
    logic [WA-1:0] hi_a;
    logic [WA-1:0] blk_a;
    logic [15:0]   rem_size;
    logic [16:0]   merge_sum;
    logic          fits;
    logic          we;
    logic          re;
    logic [WA-1:0] wa;
    logic [WA-1:0] ra;
    t_hdr          wd;

    assign rd_hdr    = r_rd_oob ? HDR_DEAD : r_rdata;
    assign next_a    = r_a + WA'(r_p.size) + WA'(1);
    assign split_a   = r_a + WA'(r_req.req_size) + WA'(1);
    assign hi_a      = r_a + WA'(r_p.size) - WA'(r_req.req_size);
    assign blk_a     = WA'(r_req.block);
    assign rem_size  = r_p.size - r_req.req_size - 16'd1;
    assign merge_sum = {1'b0, r_p.size} + {1'b0, r_q.size} + 17'd1;
    assign fits      = r_p.size >= r_req.req_size;

    always_comb begin
        o_stat.act        = r_req.action;
        o_stat.mode       = r_req.fit_mode;
        o_stat.p_valid    = (r_p.size != SIZE_DEAD) && !r_p.htype[1];
        o_stat.p_free     = r_p.owner == 16'd0;
        o_stat.p_type     = r_p.htype;
        o_stat.q_free     = r_q.owner == 16'd0;
        o_stat.q_valid    = (r_q.size != SIZE_DEAD) && !r_q.htype[1];
        o_stat.join_ovf   = merge_sum >= 17'h0ffff;
        o_stat.next_oob   = next_a >= LIMIT;
        o_stat.req_gt     = r_req.req_size > r_p.size;
        o_stat.req_lt     = r_req.req_size < r_p.size;
        o_stat.split_need = (r_req.fit_mode != FIT_LARGEST) && (r_req.req_size != r_p.size);
        o_stat.stop       = (r_req.fit_mode == FIT_FIRST) && fits;
        o_stat.found      = r_found;
        o_stat.fs_zero    = r_fs == 16'd0;
        o_stat.blk_zero   = r_req.block == 12'd0;
    end

    assign o_result = r_out;

    always_comb begin
        we = 1'b0;
        wa = r_a;
        wd = r_p;
        re = (i_cmd.op == OP_RD_A) || (i_cmd.op == OP_RD_Q);
        ra = (i_cmd.op == OP_RD_Q) ? r_qa : r_a;
        unique case (i_cmd.op)
            OP_J_WQ: begin
                we = 1'b1;
                wa = r_qa;
                wd = '{htype: r_q.htype, owner: r_q.owner, size: SIZE_DEAD};
            end
            OP_J_WP: begin
                we = 1'b1;
                wd = '{htype: r_q.htype, owner: r_p.owner, size: merge_sum[15:0]};
            end
            OP_AL_W_LO: begin
                we = 1'b1;
                if (r_req.fit_mode == FIT_LAST) begin
                    wd = '{htype: HT_NORMAL, owner: 16'd0, size: rem_size};
                end else begin
                    wa = split_a;
                    wd = '{htype: r_p.htype, owner: 16'd0, size: rem_size};
                end
            end
            OP_AL_W_HI: begin
                we = 1'b1;
                if (r_req.fit_mode == FIT_LAST) begin
                    wa = hi_a;
                    wd = '{htype: r_p.htype, owner: r_req.owner, size: r_req.req_size};
                end else begin
                    wd = '{htype: HT_NORMAL, owner: r_req.owner, size: r_req.req_size};
                end
            end
            OP_AL_W_ALL, OP_RS_OWN_EQ: begin
                we = 1'b1;
                wd = '{htype: r_p.htype, owner: r_req.owner, size: r_p.size};
            end
            OP_RS_SPLIT1: begin
                we = 1'b1;
                wa = split_a;
                wd = '{htype: r_p.htype, owner: 16'd0, size: rem_size};
            end
            OP_RS_SPLIT2: begin
                we = 1'b1;
                wd = '{htype: HT_NORMAL, owner: r_p.owner, size: r_req.req_size};
            end
            OP_RS_OWN_SH: begin
                we = 1'b1;
                wa = blk_a;
                wd = '{htype: HT_NORMAL, owner: r_req.owner, size: r_req.req_size};
            end
            OP_FREE_W: begin
                we = 1'b1;
                wd = '{htype: r_p.htype, owner: 16'd0, size: r_p.size};
            end
            OP_WALK_W: begin
                we = (r_req.action == ACT_FREE_OWN) && (r_p.owner == r_req.owner)
                     && (r_a != '0);
                wd = '{htype: r_p.htype, owner: 16'd0, size: r_p.size};
            end
            OP_HDR_W: begin
                we = 1'b1;
                wa = blk_a;
                wd = '{htype: r_req.hdr_type, owner: r_req.owner, size: r_req.hdr_size};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we && (wa < LIMIT)) begin
            r_mem[wa[AW-1:0]] <= wd;
        end
        if (re) begin
            r_rdata  <= r_mem[ra[AW-1:0]];
            r_rd_oob <= ra >= LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_req <= i_req;
                if ((i_req.action == ACT_ALLOC) || (i_req.action == ACT_CHECK)
                    || (i_req.action == ACT_FREE_OWN)) begin
                    r_a <= WA'(i_arena_start);
                end else begin
                    r_a <= WA'(i_req.block);
                end
                r_found <= 1'b0;
                r_big   <= 1'b0;
                r_fs    <= '0;
                r_bs    <= '0;
                r_fa    <= '0;
                r_ba    <= '0;
                r_st    <= ST_OK;
                r_blk   <= '0;
                r_sz    <= '0;
            end
            OP_LD_P:    r_p  <= rd_hdr;
            OP_LD_Q:    r_q  <= rd_hdr;
            OP_CALC_QA: r_qa <= next_a;
            OP_J_WP: begin
                r_p.htype <= r_q.htype;
                r_p.size  <= merge_sum[15:0];
            end
            OP_AL_EVAL: begin
                if (!r_big || (r_bs < r_p.size)) begin
                    r_big <= 1'b1;
                    r_bs  <= r_p.size;
                    r_ba  <= r_a;
                end
                if (fits) begin
                    priority if (r_req.fit_mode == FIT_LAST) begin
                        r_found <= 1'b1;
                        r_fa    <= r_a;
                        r_fs    <= r_p.size;
                    end else if (r_req.fit_mode == FIT_BEST) begin
                        if (!r_found || (r_fs > r_p.size)) begin
                            r_found <= 1'b1;
                            r_fa    <= r_a;
                            r_fs    <= r_p.size;
                        end
                    end else if (r_req.fit_mode == FIT_FIRST) begin
                        r_found <= 1'b1;
                        r_fa    <= r_a;
                        r_fs    <= r_p.size;
                    end else begin
                    end
                end
            end
            OP_ADV: r_a <= next_a;
            OP_PICK_BIG: begin
                if ((r_req.fit_mode == FIT_LARGEST) && r_big && (r_bs >= r_req.req_size)) begin
                    r_found <= 1'b1;
                    r_fa    <= r_ba;
                    r_fs    <= r_bs;
                end
            end
            OP_NOMEM_AL: begin
                r_st <= ST_NOMEM;
                r_sz <= r_big ? r_bs : 16'd0;
            end
            OP_SET_FA: r_a <= r_fa;
            OP_AL_W_HI: begin
                r_blk <= (r_req.fit_mode == FIT_LAST) ? hi_a[11:0] : r_a[11:0];
                r_sz  <= r_req.req_size;
            end
            OP_AL_W_ALL: begin
                r_blk <= r_a[11:0];
                r_sz  <= r_p.size;
            end
            OP_RS_NOMEM: begin
                r_st <= ST_NOMEM;
                r_sz <= r_p.size;
            end
            OP_RS_SPLIT1: begin
                r_qa <= split_a;
                r_q  <= '{htype: r_p.htype, owner: 16'd0, size: rem_size};
            end
            OP_RS_MOVE: begin
                r_a <= r_qa;
                r_p <= (r_qa >= LIMIT) ? HDR_DEAD : r_q;
            end
            OP_RS_OWN_EQ, OP_RS_OWN_SH: r_sz <= r_req.req_size;
            OP_QUERY: begin
                if ((r_p.size != SIZE_DEAD) && !r_p.htype[1] && (r_p.owner == r_req.owner)) begin
                    r_sz <= r_p.size;
                end
            end
            OP_SET_ST: r_st <= i_cmd.st;
            OP_EMIT:   r_out <= '{status: r_st, block_out: r_blk, size_out: r_sz};
            default: ;
        endcase
    end

endmodule

@@ rtl/core/mcba_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcba_ctrl
// Sequencer that walks the header chain and drives the datapath.
// ----------------------------------------------------------------------------
module mcba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    input  mcba_pkg::t_dp_stat i_stat,
    output mcba_pkg::t_dp_cmd  o_cmd
);
    import mcba_pkg::*;

    t_state r_state, n_state;
    t_state r_jret, n_jret;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_jret    <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_jret    <= n_jret;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_jret    = r_jret;
        n_m_valid = r_m_valid && !i_m_ready;
        o_s_ready = 1'b0;
        o_cmd     = '{op: OP_NONE, st: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                priority case (i_stat.act)
                    ACT_WRITE_HDR: begin
                        o_cmd.op = OP_HDR_W;
                        n_state  = S_DONE;
                    end
                    ACT_NOP: n_state = S_DONE;
                    default: n_state = S_RD;
                endcase
            end
            S_RD: begin
                o_cmd.op = OP_RD_A;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.op = OP_LD_P;
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_state = S_DONE;
                priority case (i_stat.act)
                    ACT_ALLOC: begin
                        priority if (!i_stat.p_valid) begin
                            o_cmd = '{op: OP_SET_ST, st: ST_DESTROYED};
                        end else if (i_stat.p_free) begin
                            n_jret  = S_AL_EVAL;
                            n_state = S_J_TOP;
                        end else if (i_stat.p_type == HT_LAST) begin
                            n_state = S_AL_END;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                    ACT_FREE: begin
                        if (i_stat.blk_zero || i_stat.p_type[1]) begin
                            o_cmd = '{op: OP_SET_ST, st: ST_INVALID};
                        end else begin
                            o_cmd.op = OP_FREE_W;
                        end
                    end
                    ACT_RESIZE: begin
                        priority if (!i_stat.p_valid) begin
                            o_cmd = '{op: OP_SET_ST, st: ST_DESTROYED};
                        end else if (i_stat.req_gt) begin
                            n_jret  = S_RS_GROW;
                            n_state = S_J_TOP;
                        end else begin
                            n_state = S_RS_SHR;
                        end
                    end
                    ACT_QUERY: o_cmd.op = OP_QUERY;
                    ACT_CHECK, ACT_FREE_OWN: begin
                        if (!i_stat.p_valid) begin
                            o_cmd = '{op: OP_SET_ST, st: ST_DESTROYED};
                        end else begin
                            o_cmd.op = OP_WALK_W;
                            if (i_stat.p_type != HT_LAST) begin
                                n_state = S_NEXT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_NEXT: begin
                if (i_stat.next_oob) begin
                    o_cmd   = '{op: OP_SET_ST, st: ST_DESTROYED};
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state  = S_RD;
                end
            end
            S_J_TOP: begin
                if (i_stat.p_type != HT_NORMAL) begin
                    n_state = r_jret;
                end else begin
                    o_cmd.op = OP_CALC_QA;
                    n_state  = S_J_RDQ;
                end
            end
            S_J_RDQ: begin
                o_cmd.op = OP_RD_Q;
                n_state  = S_J_LDQ;
            end
            S_J_LDQ: begin
                o_cmd.op = OP_LD_Q;
                n_state  = S_J_CHK;
            end
            S_J_CHK: begin
                priority if (!i_stat.q_free) begin
                    n_state = r_jret;
                end else if (!i_stat.q_valid || i_stat.join_ovf) begin
                    o_cmd   = '{op: OP_SET_ST, st: ST_DESTROYED};
                    n_state = S_DONE;
                end else begin
                    n_state = S_J_WQ;
                end
            end
            S_J_WQ: begin
                o_cmd.op = OP_J_WQ;
                n_state  = S_J_WP;
            end
            S_J_WP: begin
                o_cmd.op = OP_J_WP;
                n_state  = S_J_TOP;
            end
            S_AL_EVAL: begin
                o_cmd.op = OP_AL_EVAL;
                priority if (i_stat.stop) begin
                    n_state = S_AL_FA;
                end else if (i_stat.p_type == HT_LAST) begin
                    n_state = S_AL_END;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_AL_END: begin
                o_cmd.op = OP_PICK_BIG;
                n_state  = S_AL_END2;
            end
            S_AL_END2: begin
                if (!i_stat.found || i_stat.fs_zero) begin
                    o_cmd.op = OP_NOMEM_AL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_AL_FA;
                end
            end
            S_AL_FA: begin
                o_cmd.op = OP_SET_FA;
                n_state  = S_AL_RD;
            end
            S_AL_RD: begin
                o_cmd.op = OP_RD_A;
                n_state  = S_AL_LD;
            end
            S_AL_LD: begin
                o_cmd.op = OP_LD_P;
                n_state  = S_AL_SPLIT;
            end
            S_AL_SPLIT: begin
                if (i_stat.split_need) begin
                    o_cmd.op = OP_AL_W_LO;
                    n_state  = S_AL_WHI;
                end else begin
                    o_cmd.op = OP_AL_W_ALL;
                    n_state  = S_DONE;
                end
            end
            S_AL_WHI: begin
                o_cmd.op = OP_AL_W_HI;
                n_state  = S_DONE;
            end
            S_RS_GROW: begin
                if (i_stat.req_gt) begin
                    o_cmd.op = OP_RS_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_RS_SHR;
                end
            end
            S_RS_SHR: begin
                if (i_stat.req_lt) begin
                    o_cmd.op = OP_RS_SPLIT1;
                    n_state  = S_RS_SP2;
                end else begin
                    o_cmd.op = OP_RS_OWN_EQ;
                    n_state  = S_DONE;
                end
            end
            S_RS_SP2: begin
                o_cmd.op = OP_RS_SPLIT2;
                n_state  = S_RS_MOVE;
            end
            S_RS_MOVE: begin
                o_cmd.op = OP_RS_MOVE;
                n_jret   = S_RS_FIN;
                n_state  = S_J_TOP;
            end
            S_RS_FIN: begin
                o_cmd.op = OP_RS_OWN_SH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.op  = OP_EMIT;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/core/mcb_chain_allocator_top.sv @@
// ----------------------------------------------------------------------------
// mcb_chain_allocator_top
// Header chain allocator: alloc, free, resize, query, check, free owner, write header, no-op.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Every header visit goes
// through read, load, decide and advance steps on the single read port of
// the header store. A free header seen by an alloc adds a neighbor probe and
// an evaluate step, and every join of a free neighbor adds its own read, load,
// check and two writes. The next item is accepted while the previous result
// waits in the output register. The header store needs no clearing after
// reset; it must be laid down with write header items before use.
module mcb_chain_allocator_top #(
    parameter int ARENA_PARAS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // req_size[15:0], block[27:16], owner[43:28], hdr_type[45:44], hdr_size[61:46]
    input  logic [63:0] i_s_tdata,
    // action[2:0], fit_mode[4:3]
    input  logic [7:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], block_out[13:2], size_out[29:14]
    output logic [31:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcba_pkg::*;

    logic [11:0] r_arena_start;
    t_req        req;
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    t_result     result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {20'd0, r_arena_start} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_start <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_arena_start <= pwdata[11:0];
        end
    end

    assign req.action   = t_action'(i_s_tuser[2:0]);
    assign req.fit_mode = i_s_tuser[4:3];
    assign req.req_size = i_s_tdata[15:0];
    assign req.block    = i_s_tdata[27:16];
    assign req.owner    = i_s_tdata[43:28];
    assign req.hdr_type = i_s_tdata[45:44];
    assign req.hdr_size = i_s_tdata[61:46];

    mcba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_m_ready (i_m_tready),
        .o_m_valid (o_m_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    mcba_datapath #(
        .ARENA_PARAS (ARENA_PARAS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_req         (req),
        .i_arena_start (r_arena_start),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (result)
    );

    assign o_m_tdata = {2'd0, result.size_out, result.block_out, result.status};

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transfer accepted while an item is in work");

    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != ST_OK)) |-> (o_m_tdata[13:2] == 12'd0))
        else $error("failed request reports a block");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

@@ dv/tb_mcb_chain_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_mcb_chain_allocator_top
// Stream-level test of the header chain allocator. A chain of headers is laid
// down with write header transfers, then directed and random requests run
// against it in several phases, each with its own arena start. A predictor
// keeps its own copy of the header store and works out each result; requests
// that would touch a header never written are dropped before they are sent.
// Both stream sides idle at random but in one phase, and the receiver holds
// off once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_mcb_chain_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcba_pkg::*;

    localparam int ARENA      = 4096;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic [7:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mcb_chain_allocator_top #(.ARENA_PARAS(ARENA)) u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    t_hdr        hdr_mem [ARENA];
    bit          hdr_wr  [ARENA];
    int          hdr_list[$];
    int          arena_base;
    bit          touched_blank;
    t_hdr        mem_save[ARENA];
    bit          wr_save [ARENA];

    t_req        pending_reqs[$];
    t_result     expected_results[$];
    int          errors = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    bit          no_idle = 0;
    bit          in_fire = 0;
    bit          out_fire = 0;
    int          idle_cycles = 0;

    function automatic t_hdr hdr_get(int a);
        if (a >= ARENA) return HDR_DEAD;
        if (!hdr_wr[a]) touched_blank = 1'b1;
        return hdr_mem[a];
    endfunction

    function automatic void hdr_put(int a, t_hdr h);
        if (a < ARENA) begin
            if (!hdr_wr[a]) hdr_list.push_back(a);
            hdr_mem[a] = h;
            hdr_wr[a] = 1'b1;
        end
    endfunction

    function automatic bit hdr_ok(t_hdr h);
        return h.size != SIZE_DEAD && h.htype <= HT_LAST;
    endfunction

    function automatic bit coalesce(int a);
        t_hdr p, q;
        int qa;
        p = hdr_get(a);
        while (p.htype == HT_NORMAL) begin
            qa = a + int'(p.size) + 1;
            q = hdr_get(qa);
            if (q.owner != 0) break;
            if (!hdr_ok(q)) return 0;
            if (int'(p.size) + int'(q.size) + 1 >= 65535) return 0;
            p.htype = q.htype;
            p.size = p.size + q.size + 16'd1;
            q.size = SIZE_DEAD;
            hdr_put(qa, q);
            hdr_put(a, p);
        end
        return 1;
    endfunction

    function automatic t_result predict_alloc(int req, logic [1:0] mode, logic [15:0] owner);
        int a, fa, fs, ba, bs, ra;
        bit found, big, stop;
        t_hdr p, rem, got;
        t_result r;
        r = '{status: ST_OK, block_out: 12'd0, size_out: 16'd0};
        a = arena_base; fa = 0; fs = 0; ba = 0; bs = 0;
        found = 0; big = 0; stop = 0;
        while (1) begin
            p = hdr_get(a);
            if (!hdr_ok(p)) begin r.status = ST_DESTROYED; return r; end
            if (p.owner == 0) begin
                if (!coalesce(a)) begin r.status = ST_DESTROYED; return r; end
                p = hdr_get(a);
                if (!big || bs < int'(p.size)) begin big = 1; bs = p.size; ba = a; end
                if (int'(p.size) >= req) begin
                    if (mode == FIT_LAST) begin
                        found = 1; fa = a; fs = p.size;
                    end else if (mode == FIT_BEST) begin
                        if (!found || fs > int'(p.size)) begin found = 1; fa = a; fs = p.size; end
                    end else if (mode == FIT_FIRST) begin
                        found = 1; fa = a; fs = p.size; stop = 1;
                    end
                end
            end
            if (stop || p.htype == HT_LAST) break;
            if (a + int'(p.size) + 1 >= ARENA) begin r.status = ST_DESTROYED; return r; end
            a = a + int'(p.size) + 1;
        end
        if (!stop) begin
            if (mode == FIT_LARGEST && big && bs >= req) begin found = 1; fa = ba; fs = bs; end
            if (!found || fs == 0) begin
                r.status = ST_NOMEM;
                r.size_out = big ? bs[15:0] : 16'd0;
                return r;
            end
        end
        p = hdr_get(fa);
        if (mode != FIT_LARGEST && req != int'(p.size)) begin
            if (mode == FIT_LAST) begin
                rem = p;
                rem.size = p.size - req[15:0] - 16'd1;
                ra = fa;
                fa = ra + int'(rem.size) + 1;
                got.htype = p.htype;
                got.size = req[15:0];
                got.owner = owner;
                rem.htype = HT_NORMAL;
                rem.owner = 16'd0;
                hdr_put(ra, rem);
                hdr_put(fa, got);
            end else begin
                rem.htype = p.htype;
                rem.size = p.size - req[15:0] - 16'd1;
                rem.owner = 16'd0;
                p.htype = HT_NORMAL;
                p.size = req[15:0];
                p.owner = owner;
                hdr_put(fa + req + 1, rem);
                hdr_put(fa, p);
            end
            r.size_out = req[15:0];
        end else begin
            p.owner = owner;
            hdr_put(fa, p);
            r.size_out = p.size;
        end
        r.block_out = fa[11:0];
        return r;
    endfunction

    function automatic t_result predict_resize(int a, int req, logic [15:0] owner);
        t_hdr p, q;
        int qa;
        t_result r;
        r = '{status: ST_OK, block_out: 12'd0, size_out: 16'd0};
        p = hdr_get(a);
        if (!hdr_ok(p)) begin r.status = ST_DESTROYED; return r; end
        if (req > int'(p.size)) begin
            if (!coalesce(a)) begin r.status = ST_DESTROYED; return r; end
            p = hdr_get(a);
            if (req > int'(p.size)) begin
                r.status = ST_NOMEM;
                r.size_out = p.size;
                return r;
            end
        end
        if (req < int'(p.size)) begin
            qa = a + req + 1;
            q.size = p.size - req[15:0] - 16'd1;
            q.htype = p.htype;
            q.owner = 16'd0;
            p.size = req[15:0];
            p.htype = HT_NORMAL;
            hdr_put(qa, q);
            hdr_put(a, p);
            if (!coalesce(qa)) begin r.status = ST_DESTROYED; return r; end
            p = hdr_get(a);
        end
        p.owner = owner;
        hdr_put(a, p);
        r.size_out = req[15:0];
        return r;
    endfunction

    function automatic t_status walk_chain(bit release_owner, logic [15:0] owner);
        int a;
        t_hdr p;
        a = arena_base;
        while (1) begin
            p = hdr_get(a);
            if (!hdr_ok(p)) return ST_DESTROYED;
            if (release_owner && p.owner == owner && a != 0) begin
                p.owner = 16'd0;
                hdr_put(a, p);
            end
            if (p.htype == HT_LAST) return ST_OK;
            if (a + int'(p.size) + 1 >= ARENA) return ST_DESTROYED;
            a = a + int'(p.size) + 1;
        end
    endfunction

    function automatic t_result predict_request(t_req q);
        t_result r;
        t_hdr p;
        r = '{status: ST_OK, block_out: 12'd0, size_out: 16'd0};
        case (q.action)
            ACT_ALLOC: r = predict_alloc(q.req_size, q.fit_mode, q.owner);
            ACT_FREE: begin
                p = hdr_get(q.block);
                if (q.block == 0 || p.htype > HT_LAST) begin
                    r.status = ST_INVALID;
                end else begin
                    p.owner = 16'd0;
                    hdr_put(q.block, p);
                end
            end
            ACT_RESIZE: r = predict_resize(q.block, q.req_size, q.owner);
            ACT_QUERY: begin
                p = hdr_get(q.block);
                if (hdr_ok(p) && p.owner == q.owner) r.size_out = p.size;
            end
            ACT_CHECK: r.status = walk_chain(1'b0, 16'd0);
            ACT_FREE_OWN: r.status = walk_chain(1'b1, q.owner);
            ACT_WRITE_HDR: begin
                p.htype = q.hdr_type;
                p.owner = q.owner;
                p.size = q.hdr_size;
                hdr_put(q.block, p);
            end
            default: ;
        endcase
        return r;
    endfunction

    // predict on the live state; roll back and drop the request if it
    // would read a header that was never written
    function automatic bit issue(t_req q);
        int list_len;
        t_result r;
        mem_save = hdr_mem;
        wr_save = hdr_wr;
        list_len = hdr_list.size();
        touched_blank = 1'b0;
        r = predict_request(q);
        if (touched_blank) begin
            hdr_mem = mem_save;
            hdr_wr = wr_save;
            while (hdr_list.size() > list_len) void'(hdr_list.pop_back());
            return 0;
        end
        pending_reqs.push_back(q);
        expected_results.push_back(r);
        return 1;
    endfunction

    function automatic t_req mk_req(t_action act, int req, logic [1:0] mode, int blk,
                                    logic [15:0] owner, logic [1:0] ht, logic [15:0] hs);
        t_req q;
        q.action = act;
        q.req_size = req[15:0];
        q.fit_mode = mode;
        q.block = blk[11:0];
        q.owner = owner;
        q.hdr_type = ht;
        q.hdr_size = hs;
        return q;
    endfunction

    function automatic logic [15:0] pick_owner();
        int k;
        k = $urandom_range(0, 99);
        if (k < 85) return 16'($urandom_range(1, 6));
        if (k < 92) return 16'd0;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return $urandom_range(0, 20);
        if (k < 90) return $urandom_range(0, 80);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int pick_block();
        if (hdr_list.size() > 0 && $urandom_range(0, 99) < 85)
            return hdr_list[$urandom_range(0, hdr_list.size() - 1)];
        return $urandom_range(0, ARENA - 1);
    endfunction

    function automatic t_req random_req();
        int k;
        k = $urandom_range(0, 99);
        if (k < 32)
            return mk_req(ACT_ALLOC, pick_size(), 2'($urandom_range(0, 3)), 0,
                          pick_owner(), 2'd0, 16'd0);
        if (k < 47)
            return mk_req(ACT_FREE, 0, 2'd0, pick_block(), pick_owner(), 2'd0, 16'd0);
        if (k < 62)
            return mk_req(ACT_RESIZE, pick_size(), 2'd0, pick_block(), pick_owner(),
                          2'd0, 16'd0);
        if (k < 72)
            return mk_req(ACT_QUERY, 0, 2'd0, pick_block(), pick_owner(), 2'd0, 16'd0);
        if (k < 78)
            return mk_req(ACT_CHECK, 0, 2'd0, 0, 16'd0, 2'd0, 16'd0);
        if (k < 86)
            return mk_req(ACT_FREE_OWN, 0, 2'd0, 0, pick_owner(), 2'd0, 16'd0);
        if (k < 97)
            return mk_req(t_action'($urandom_range(0, 7)), $urandom_range(0, 65535),
                          2'($urandom_range(0, 3)), pick_block(), pick_owner(),
                          2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        return mk_req(ACT_WRITE_HDR, 0, 2'd0, $urandom_range(0, ARENA - 1),
                      16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                      16'($urandom_range(0, 65535)));
    endfunction

    task automatic lay_chain(int start, int max_blocks);
        int a, sz, n;
        a = start;
        n = 0;
        while (1) begin
            sz = $urandom_range(0, 30);
            n++;
            if (n >= max_blocks || a + sz + 1 >= ARENA) begin
                if (a + sz >= ARENA) sz = ARENA - 1 - a;
                void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, a, 16'd0, HT_LAST, sz[15:0])));
                break;
            end
            void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, a,
                               ($urandom_range(0, 2) == 0) ? pick_owner() : 16'd0,
                               HT_NORMAL, sz[15:0])));
            a = a + sz + 1;
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_arena(int start);
        drain();
        apb_write(3'd0, 32'(start));
        arena_base = start;
    endtask

    task automatic random_phase(int count);
        int sent, tries;
        sent = 0;
        while (sent < count) begin
            tries = 0;
            while (tries < 20 && !issue(random_req())) tries++;
            sent++;
            if (tries >= 20) begin
                void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, $urandom_range(0, 4095),
                                   16'd0, HT_NORMAL, 16'd0)));
            end
            if (sent % 120 == 0) lay_chain(arena_base, $urandom_range(4, 20));
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        t_req q;
        if (i_rst_n && (!i_s_tvalid || in_fire)) begin
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
                q = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                // req_size, block, owner, hdr_type, hdr_size from bit 0 up
                i_s_tdata <= {2'b00, q.hdr_size, q.hdr_type, q.owner, q.block, q.req_size};
                // action, fit_mode from bit 0 up
                i_s_tuser <= {3'b000, q.fit_mode, q.action};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_tready <= no_idle || $urandom_range(0, 99) >= 26;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_result got, want;
        in_fire = i_s_tvalid && o_s_tready;
        out_fire = o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (out_fire) begin
                got = '{status: t_status'(o_m_tdata[1:0]), block_out: o_m_tdata[13:2],
                        size_out: o_m_tdata[29:14]};
                results_seen++;
                if (results_seen == 400 && !hold_done) begin
                    hold_done = 1'b1;
                    hold_left = HOLD_LEN;
                end
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, actual %h", $time, o_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    end
                    if (got.block_out != want.block_out) begin
                        errors++;
                        $display("%0t: block_out expected %0d actual %0d", $time,
                                 want.block_out, got.block_out);
                    end
                    if (got.size_out != want.size_out) begin
                        errors++;
                        $display("%0t: size_out expected %0d actual %0d", $time,
                                 want.size_out, got.size_out);
                    end
                end
            end
            if (in_fire || out_fire || (pending_reqs.size() == 0 &&
                                         expected_results.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        int starts[5];
        arena_base = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: chain at paragraph 0
        set_arena(0);
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 0, 16'd0, HT_NORMAL, 16'd0)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 1, 16'd0, HT_NORMAL, 16'd10)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 12, 16'd3, HT_NORMAL, 16'd4)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 17, 16'd0, HT_NORMAL, 16'd20)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 38, 16'd0, HT_LAST, 16'd30)));
        void'(issue(mk_req(ACT_ALLOC, 0, FIT_FIRST, 0, 16'd5, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_ALLOC, 0, FIT_BEST, 0, 16'd5, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_ALLOC, 3, FIT_BEST, 0, 16'd5, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_ALLOC, 4, FIT_LAST, 0, 16'hffff, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_ALLOC, 2, FIT_LARGEST, 0, 16'd7, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_ALLOC, 65535, FIT_FIRST, 0, 16'd7, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_QUERY, 0, 2'd0, 12, 16'd3, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_QUERY, 0, 2'd0, 12, 16'd4, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_FREE, 0, 2'd0, 0, 16'd0, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_FREE, 0, 2'd0, 12, 16'd0, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_RESIZE, 40, 2'd0, 1, 16'd9, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_RESIZE, 2, 2'd0, 1, 16'd9, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_CHECK, 0, 2'd0, 0, 16'd0, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_FREE_OWN, 0, 2'd0, 0, 16'd5, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_NOP, 65535, 2'd3, 4095, 16'hffff, 2'd3, 16'hffff)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 12, 16'd0, 2'd3, 16'd4)));
        void'(issue(mk_req(ACT_FREE, 0, 2'd0, 12, 16'd0, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_CHECK, 0, 2'd0, 0, 16'd0, 2'd0, 16'd0)));
        void'(issue(mk_req(ACT_WRITE_HDR, 0, 2'd0, 38, 16'd0, HT_LAST, 16'hffff)));
        void'(issue(mk_req(ACT_CHECK, 0, 2'd0, 0, 16'd0, 2'd0, 16'd0)));

        starts = '{0, 4095, 2048, $urandom_range(1, 4000), 4000};
        foreach (starts[i]) begin
            set_arena(starts[i]);
            no_idle = (i == 2);
            lay_chain(starts[i], $urandom_range(4, 24));
            random_phase(250);
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
